FILE: rtl/mtpi_pkg.sv
// Shared types and constants for the Moore tree parent index block.
package mtpi_pkg;

  localparam int DEG_W   = 8;
  localparam int DEPTH_W = 5;

  localparam logic [DEG_W-1:0] DEG_MIN   = 8'd3;
  localparam logic [DEG_W-1:0] DEG_RESET = 8'd3;

  typedef struct packed {
    logic load;
    logic step;
    logic add;
    logic div_init;
    logic div_step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic v_zero;
    logic past_bound;
    logic dep_one;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/mtpi_dp.sv
// Datapath: degree register, level search, serial divider and output register.
module mtpi_dp #(
  parameter int VERTEX_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [mtpi_pkg::DEG_W-1:0]    cfg_data_i,
  input  logic [VERTEX_BITS-1:0]        vertex_index_i,
  input  mtpi_pkg::cmd_t                cmd_i,
  output mtpi_pkg::sts_t                sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [VERTEX_BITS-1:0]        parent_index_o,
  output logic                          has_parent_o,
  output logic [mtpi_pkg::DEPTH_W-1:0]  depth_o
);
  import mtpi_pkg::*;

  localparam int LW  = VERTEX_BITS + DEG_W;
  localparam int NBW = LW + 1;
  localparam int CW  = $clog2(VERTEX_BITS);

  logic [DEG_W-1:0]       deg_q;
  logic [DEG_W-1:0]       eff_deg;
  logic [DEG_W-1:0]       dm1_q;
  logic [VERTEX_BITS-1:0] v_q;
  logic [VERTEX_BITS-1:0] bound_q;
  logic [VERTEX_BITS-1:0] prev_q;
  logic [LW-1:0]          level_q;
  logic [NBW-1:0]         next_q;
  logic [DEPTH_W-1:0]     dep_q;
  logic [DEG_W-1:0]       rem_q;
  logic [VERTEX_BITS-1:0] quo_q;
  logic [CW-1:0]          cnt_q;
  logic [DEG_W:0]         trial;
  logic                   trial_ok;
  logic                   out_valid_q;
  logic                   out_valid_d;
  logic [VERTEX_BITS-1:0] parent_q;
  logic [VERTEX_BITS-1:0] parent_d;
  logic                   has_parent_q;
  logic [DEPTH_W-1:0]     depth_q;

  assign eff_deg  = (deg_q < DEG_MIN) ? DEG_MIN : deg_q;
  assign trial    = {rem_q, quo_q[VERTEX_BITS-1]};
  assign trial_ok = trial >= {1'b0, dm1_q};

  assign sts_o.v_zero     = (v_q == '0);
  assign sts_o.past_bound = {{(NBW-VERTEX_BITS){1'b0}}, v_q} >= next_q;
  assign sts_o.dep_one    = (dep_q == DEPTH_W'(1));
  assign sts_o.div_last   = (cnt_q == CW'(VERTEX_BITS - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign parent_d = (sts_o.v_zero || sts_o.dep_one) ? '0 : (quo_q + prev_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.publish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q       <= DEG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        deg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q     <= vertex_index_i;
      dm1_q   <= eff_deg - DEG_W'(1);
      bound_q <= VERTEX_BITS'(1);
      prev_q  <= VERTEX_BITS'(1);
      level_q <= LW'(eff_deg);
      next_q  <= NBW'(eff_deg) + NBW'(1);
      dep_q   <= DEPTH_W'(1);
    end
    if (cmd_i.step) begin
      prev_q  <= bound_q;
      bound_q <= next_q[VERTEX_BITS-1:0];
      level_q <= LW'(level_q[VERTEX_BITS-1:0]) * LW'(dm1_q);
      dep_q   <= dep_q + DEPTH_W'(1);
    end
    if (cmd_i.add) begin
      next_q <= NBW'(bound_q) + NBW'(level_q);
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= v_q - bound_q;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_ok ? DEG_W'(trial - {1'b0, dm1_q}) : trial[DEG_W-1:0];
      quo_q <= {quo_q[VERTEX_BITS-2:0], trial_ok};
      cnt_q <= cnt_q + CW'(1);
    end
    if (cmd_i.publish) begin
      parent_q     <= parent_d;
      has_parent_q <= !sts_o.v_zero;
      depth_q      <= sts_o.v_zero ? '0 : dep_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign parent_index_o = parent_q;
  assign has_parent_o   = has_parent_q;
  assign depth_o        = depth_q;

endmodule

FILE: rtl/mtpi_ctrl.sv
// Controller: sequences level search, division and result hand-off.
module mtpi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mtpi_pkg::sts_t sts_i,
  output mtpi_pkg::cmd_t cmd_o
);
  import mtpi_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_DINIT = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.v_zero) begin
          state_d = ST_FIN;
        end else if (sts_i.past_bound) begin
          cmd_o.step = 1'b1;
          state_d    = ST_ADD;
        end else if (sts_i.dep_one) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_DINIT;
        end
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_CHECK;
      end
      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> sts_i.out_free)
    else $error("result published while output register still full");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.add, cmd_o.div_init,
              cmd_o.div_step, cmd_o.publish}))
    else $error("more than one datapath command at once");

  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && sts_i.div_last) |=> (state_q == ST_FIN))
    else $error("divider did not finish after its last step");

  a_step_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |=> cmd_o.add)
    else $error("level step not followed by bound update");
`endif

endmodule

FILE: rtl/moore_tree_parent_index.sv
// Top level: Moore tree vertex depth and parent index lookup.
// The level search loop (per level a multiply step, then an add) and the bit-serial divider
// set the time from input beat to result beat; the root and depth-one vertices skip the divider.
// One item is in flight at a time, so a new beat is not taken until the last result is
// published to the output register, but it is taken even while that result still waits there.
// Reset clears the controller and output valid and sets the degree register to 3.
module moore_tree_parent_index #(
  parameter int VERTEX_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mtpi_pkg::DEG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [VERTEX_BITS-1:0]        vertex_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [VERTEX_BITS-1:0]        parent_index_o,
  output logic                          has_parent_o,
  output logic [mtpi_pkg::DEPTH_W-1:0]  depth_o
);
  import mtpi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  mtpi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mtpi_dp #(
    .VERTEX_BITS (VERTEX_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .vertex_index_i (vertex_index_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .parent_index_o (parent_index_o),
    .has_parent_o   (has_parent_o),
    .depth_o        (depth_o)
  );

endmodule

FILE: bench/tb_moore_tree_parent_index.sv
// Testbench for the Moore tree parent index block: directed and random lookups
// checked against a predictor.
module tb_moore_tree_parent_index;
  timeunit 1ns;
  timeprecision 1ps;

  import mtpi_pkg::*;

  localparam int VB         = 20;
  localparam int STALL_MAX  = 3000;
  localparam int TAIL_WAIT  = 2 * 32 + VB + 8;
  localparam int LONG_HOLD  = 300;

  typedef struct packed {
    logic [VB-1:0]      parent;
    logic               has_parent;
    logic [DEPTH_W-1:0] depth;
  } lookup_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [DEG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [VB-1:0]        vertex;
  logic                 out_valid;
  logic                 out_ready;
  logic [VB-1:0]        parent_index;
  logic                 has_parent;
  logic [DEPTH_W-1:0]   depth;

  logic [DEG_W-1:0]     degree_reg;
  lookup_t              pending_lookups[64];
  logic [5:0]           lookup_wr;
  logic [5:0]           lookup_rd;
  int unsigned          err_count;
  int unsigned          idle_cycles;
  int unsigned          hold_left;
  int unsigned          rx_burst_left;
  bit                   tx_idle_en;
  bit                   rx_idle_en;

  moore_tree_parent_index #(.VERTEX_BITS(VB)) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .vertex_index_i (vertex),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .parent_index_o (parent_index),
    .has_parent_o   (has_parent),
    .depth_o        (depth)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] tree_degree(logic [DEG_W-1:0] reg_val);
    return (reg_val < DEG_MIN) ? 64'(DEG_MIN) : 64'(reg_val);
  endfunction

  // count of vertices at depth lvl or less
  function automatic logic [63:0] level_bound(logic [DEG_W-1:0] reg_val, int lvl);
    logic [63:0] d;
    logic [63:0] total;
    logic [63:0] width;
    d     = tree_degree(reg_val);
    total = 64'd1;
    width = d;
    for (int i = 1; i <= lvl; i++) begin
      total = total + width;
      width = width * (d - 64'd1);
    end
    return total;
  endfunction

  function automatic lookup_t predict_lookup(logic [VB-1:0] v, logic [DEG_W-1:0] reg_val);
    lookup_t     res;
    logic [63:0] d;
    logic [63:0] grand_start;
    logic [63:0] row_start;
    logic [63:0] row_width;
    logic [63:0] row_end;
    logic [63:0] lvl;
    logic [63:0] par;
    res = '0;
    if (v == '0) begin
      return res;
    end
    d           = tree_degree(reg_val);
    grand_start = 64'd1;
    row_start   = 64'd1;
    row_width   = d;
    row_end     = row_start + row_width;
    lvl         = 64'd1;
    while (64'(v) >= row_end) begin
      grand_start = row_start;
      row_start   = row_end;
      row_width   = row_width * (d - 64'd1);
      row_end     = row_start + row_width;
      lvl++;
    end
    par = (lvl == 64'd1) ? 64'd0 : (64'(v) - row_start) / (d - 64'd1) + grand_start;
    res.parent     = par[VB-1:0];
    res.has_parent = 1'b1;
    res.depth      = lvl[DEPTH_W-1:0];
    return res;
  endfunction

  function automatic logic [VB-1:0] pick_vertex(logic [DEG_W-1:0] reg_val);
    logic [63:0] d;
    logic [63:0] b;
    logic [63:0] pick;
    int          top;
    d = tree_degree(reg_val);
    case ($urandom_range(0, 4))
      0: pick = 64'($urandom_range(0, 32'(d) + 2));
      1: begin
        top = 1;
        while (level_bound(reg_val, top + 1) < (64'd1 << VB)) top++;
        b    = level_bound(reg_val, $urandom_range(1, top));
        pick = b + 64'($urandom_range(0, 3)) - 64'd2;
      end
      2: pick = 64'($urandom) & ((64'd1 << $urandom_range(1, VB)) - 64'd1);
      default: pick = 64'($urandom);
    endcase
    return pick[VB-1:0];
  endfunction

  // sender: hold valid across back-to-back beats, drop it only for a gap
  task automatic send_vertex(logic [VB-1:0] v);
    int gap;
    @(negedge clk);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    vertex   = v;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    pending_lookups[lookup_wr] = predict_lookup(v, degree_reg);
    lookup_wr = lookup_wr + 6'd1;
  endtask

  task automatic drain_lookups();
    @(negedge clk);
    in_valid = 1'b0;
    while (lookup_wr != lookup_rd) @(posedge clk);
  endtask

  task automatic write_degree(logic [DEG_W-1:0] val);
    drain_lookups();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    degree_reg = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_directed();
    logic [63:0] b;
    send_vertex('0);
    send_vertex(VB'(1));
    send_vertex(VB'(2));
    send_vertex(VB'(3));
    send_vertex(VB'(4));
    send_vertex(VB'(9));
    send_vertex(VB'(10));
    b = level_bound(degree_reg, 18);
    send_vertex(b[VB-1:0] - VB'(1));
    send_vertex(b[VB-1:0]);
    send_vertex('1);
    send_vertex(VB'(20'h55555));
    send_vertex(VB'(20'hAAAAA));
    write_degree(8'd0);
    send_vertex(VB'(4));
    send_vertex('1);
    write_degree(8'd2);
    send_vertex(VB'(3));
    send_vertex(VB'(4));
    write_degree(8'd255);
    send_vertex(VB'(255));
    send_vertex(VB'(256));
    send_vertex(VB'(64770));
    send_vertex(VB'(64771));
    send_vertex('1);
    write_degree(8'd1);
    send_vertex(VB'(10));
  endtask

  task automatic test_random_degrees();
    logic [DEG_W-1:0] degs[15];
    degs = '{8'd3, 8'd4, 8'd5, 8'd6, 8'd9, 8'd17, 8'd64, 8'd128, 8'd200,
             8'd254, 8'd255, 8'd0, 8'd1, 8'd2, 8'd3};
    degs[14] = DEG_W'($urandom_range(3, 255));
    foreach (degs[i]) begin
      write_degree(degs[i]);
      repeat (90) send_vertex(pick_vertex(degree_reg));
    end
  endtask

  task automatic test_backpressure();
    write_degree(8'd3);
    hold_left = LONG_HOLD;
    repeat (30) send_vertex(pick_vertex(degree_reg));
  endtask

  task automatic test_sender_pause();
    write_degree(8'd7);
    repeat (20) send_vertex(pick_vertex(degree_reg));
    drain_lookups();
    repeat (20) send_vertex(pick_vertex(degree_reg));
  endtask

  task automatic test_full_rate();
    write_degree(DEG_W'($urandom_range(3, 12)));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (180) send_vertex(pick_vertex(degree_reg));
  endtask

  // receiver: a long hold while hold_left is set, else random stall bursts when enabled
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (rx_burst_left != 0) begin
        out_ready = 1'b0;
        rx_burst_left--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        rx_burst_left = $urandom_range(0, 9);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    lookup_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (lookup_wr == lookup_rd) begin
        $error("result beat with nothing expected: parent_index=%0d depth=%0d",
               parent_index, depth);
        err_count++;
      end else begin
        exp_res   = pending_lookups[lookup_rd];
        lookup_rd = lookup_rd + 6'd1;
        if (parent_index !== exp_res.parent) begin
          $error("parent_index expected %0d actual %0d", exp_res.parent, parent_index);
          err_count++;
        end
        if (has_parent !== exp_res.has_parent) begin
          $error("has_parent expected %0d actual %0d", exp_res.has_parent, has_parent);
          err_count++;
        end
        if (depth !== exp_res.depth) begin
          $error("depth expected %0d actual %0d", exp_res.depth, depth);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_MAX) begin
      $display("moore_tree_parent_index verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    vertex        = '0;
    degree_reg    = DEG_RESET;
    lookup_wr     = '0;
    lookup_rd     = '0;
    err_count     = 0;
    idle_cycles   = 0;
    hold_left     = 0;
    rx_burst_left = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_degrees();
    test_backpressure();
    test_sender_pause();
    test_full_rate();

    drain_lookups();
    repeat (TAIL_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("moore_tree_parent_index verification clean");
    end else begin
      $display("moore_tree_parent_index verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mtpi_pkg.sv
rtl/mtpi_dp.sv
rtl/mtpi_ctrl.sv
rtl/moore_tree_parent_index.sv
bench/tb_moore_tree_parent_index.sv
